// File: rtl/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types, constants and pattern tables for the terminal escape key
// decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

   localparam int SPECIAL_BASE = 128;
   localparam int SHIFTED_BASE = 152;
   localparam int MAX_SEQ_LEN  = 5;
   localparam int NUM_PRIMARY  = 24;
   localparam int NUM_SHIFTED  = 12;
   localparam int NUM_ARROWS   = 4;
   localparam int PAT_CHARS    = 4;

   // counters hold 0..MAX_SEQ_LEN, indexes 0..MAX_SEQ_LEN-1
   localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);
   localparam int POS_W = $clog2(MAX_SEQ_LEN);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEQ_LEN);

   localparam logic [6:0] ESC_CODE     = 7'h1B;
   localparam logic [6:0] CHAR_O       = 7'h4F;
   localparam logic [6:0] CHAR_BRACKET = 7'h5B;
   localparam logic [6:0] CHAR_NUL     = 7'h00;

   // patterns after the ESC, first character in the top byte, NUL padded
   localparam logic [31:0] PRI_PAT [NUM_PRIMARY] = '{
      {"[A", 16'h0}, {"[B", 16'h0}, {"[C", 16'h0}, {"[D", 16'h0},
      {"[2~", 8'h0}, {"[3~", 8'h0}, {"[5~", 8'h0}, {"[6~", 8'h0},
      {"[7~", 8'h0}, {"[8~", 8'h0},
      "[11~", "[12~", "[13~", "[14~", "[15~", "[17~",
      "[18~", "[19~", "[20~", "[21~", "[23~", "[24~",
      {"[7^", 8'h0}, {"[8^", 8'h0}
   };

   localparam logic [31:0] SHF_PAT [NUM_SHIFTED] = '{
      "[23~", "[24~", "[25~", "[26~", "[28~", "[29~",
      "[31~", "[32~", "[33~", "[34~", "[23$", "[24$"
   };

   typedef struct packed {
      logic [7:0] key_byte;
      logic       more_waiting;
   } req_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       special_key;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                   hit;
      logic                   miss;
      logic [7:0]             code;
      logic                   set_ss3;
      logic [NUM_PRIMARY-1:0] pri_cand;
      logic [NUM_SHIFTED-1:0] shf_cand;
   } match_res_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

   typedef struct packed {
      logic             busy;
      logic             pend_valid;
      logic [CNT_W-1:0] rd_ptr;
      logic [CNT_W-1:0] fill;
   } seq_status_type;

   function automatic logic [6:0] pat_char(input logic [31:0] pat, input int pos);
      logic [7:0] ch;
      ch = pat[31-8*pos -: 8];
      return ch[6:0];
   endfunction

   function automatic int pat_len(input logic [31:0] pat);
      int   k;
      logic stop;
      k    = 0;
      stop = 1'b0;
      for (int p = 0; p < PAT_CHARS; p++) begin
         if (!stop && pat_char(pat, p) != CHAR_NUL) begin
            k++;
         end else begin
            stop = 1'b1;
         end
      end
      return k;
   endfunction

endpackage

// File: rtl/tekd_match.sv
// ----------------------------------------------------------------------------
// tekd_match
// Shared match step: compares one byte at one sequence position against all
// live candidates and reports hit, miss and the surviving candidate sets.
// ----------------------------------------------------------------------------
module tekd_match (
   input  logic [6:0]                      cur_byte,
   input  logic [tekd_pkg::POS_W-1:0]      pos,
   input  logic [tekd_pkg::NUM_PRIMARY-1:0] pri_cand,
   input  logic [tekd_pkg::NUM_SHIFTED-1:0] shf_cand,
   input  logic                            ss3_mode,
   input  logic                            prev_is_o,
   output tekd_pkg::match_res_type          res
);
   import tekd_pkg::*;

   int         plen;
   int         jm1;
   logic       ok;
   logic       found;

   always_comb begin
      res          = '0;
      res.pri_cand = pri_cand;
      res.shf_cand = shf_cand;
      found        = 1'b0;
      jm1          = int'(pos) - 1;
      plen         = 0;
      ok           = 1'b0;

      for (int i = 0; i < NUM_PRIMARY; i++) begin
         if (pri_cand[i]) begin
            plen = pat_len(PRI_PAT[i]);
            ok   = 1'b0;
            if (i < NUM_ARROWS && jm1 == 0) begin
               // arrow lead-in: either form allowed until ESC O A..D is seen
               ok = ss3_mode ? (cur_byte == CHAR_O)
                             : (cur_byte == CHAR_BRACKET || cur_byte == CHAR_O);
            end else if (jm1 < plen) begin
               ok = (cur_byte == pat_char(PRI_PAT[i], jm1));
            end
            if (ok) begin
               if (int'(pos) == plen && !found) begin
                  found       = 1'b1;
                  res.code    = 8'(SPECIAL_BASE + i);
                  res.set_ss3 = (i < NUM_ARROWS) && prev_is_o;
               end
            end else begin
               res.pri_cand[i] = 1'b0;
            end
         end
      end

      for (int i = 0; i < NUM_SHIFTED; i++) begin
         if (shf_cand[i]) begin
            plen = pat_len(SHF_PAT[i]);
            ok   = (jm1 < plen) && (cur_byte == pat_char(SHF_PAT[i], jm1));
            if (ok) begin
               if (int'(pos) == plen && !found) begin
                  found    = 1'b1;
                  res.code = 8'(SHIFTED_BASE + i);
               end
            end else begin
               res.shf_cand[i] = 1'b0;
            end
         end
      end

      res.hit  = found;
      res.miss = !found && (res.pri_cand == '0) && (res.shf_cand == '0);
   end

endmodule

// File: rtl/tekd_seq.sv
// ----------------------------------------------------------------------------
// tekd_seq
// Byte sequencer: holds the ESC sequence and the replay queue in one buffer,
// runs one match step per cycle while the output is free, stages results.
// ----------------------------------------------------------------------------
module tekd_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   input  tekd_pkg::req_type        req_data,
   input  logic                     out_free,
   output tekd_pkg::push_type       push,
   output tekd_pkg::seq_status_type status
);
   import tekd_pkg::*;

   // buf_ff[0 .. rd_ptr-1] are held sequence bytes, the rest still unparsed
   logic [6:0]             buf_ff  [MAX_SEQ_LEN];
   logic [6:0]             buf_in  [MAX_SEQ_LEN];
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   more_ff, more_in;
   logic [NUM_PRIMARY-1:0] pri_ff, pri_in;
   logic [NUM_SHIFTED-1:0] shf_ff, shf_in;
   logic                   ss3_ff, ss3_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [7:0]             pend_code_ff, pend_code_in;
   logic                   pend_special_ff, pend_special_in;

   logic                   busy;
   logic                   step;
   logic                   in_seq;
   logic                   more;
   logic [6:0]             cur_byte;
   logic                   emit;
   logic [7:0]             emit_code;
   logic                   emit_special;
   logic [CNT_W-1:0]       shift;
   logic [CNT_W:0]         next_ptr;
   int                     src;
   match_res_type          mres;

   assign busy     = (rd_ptr_ff != fill_ff);
   assign step     = busy && out_free;
   assign in_seq   = (rd_ptr_ff != '0);
   assign cur_byte = buf_ff[rd_ptr_ff[POS_W-1:0]];
   assign next_ptr = {1'b0, rd_ptr_ff} + 1'b1;
   // a byte sees more input behind it if later bytes are held or more is waiting
   assign more     = (next_ptr < {1'b0, fill_ff}) || more_ff;

   tekd_match u_match (
      .cur_byte  (cur_byte),
      .pos       (rd_ptr_ff[POS_W-1:0]),
      .pri_cand  (pri_ff),
      .shf_cand  (shf_ff),
      .ss3_mode  (ss3_ff),
      .prev_is_o (buf_ff[1] == CHAR_O),
      .res       (mres)
   );

   // step decision
   always_comb begin
      emit         = 1'b0;
      emit_code    = '0;
      emit_special = 1'b0;
      shift        = '0;
      rd_ptr_in    = rd_ptr_ff;
      pri_in       = pri_ff;
      shf_in       = shf_ff;
      ss3_in       = ss3_ff;
      if (step) begin
         if (!in_seq) begin
            pri_in = '1;
            shf_in = '1;
            if (cur_byte == ESC_CODE && more) begin
               rd_ptr_in = CNT_W'(1);
            end else begin
               emit      = 1'b1;
               emit_code = {1'b0, cur_byte};
               shift     = CNT_W'(1);
            end
         end else if (mres.hit) begin
            emit         = 1'b1;
            emit_code    = mres.code;
            emit_special = 1'b1;
            shift        = next_ptr[CNT_W-1:0];
            rd_ptr_in    = '0;
            pri_in       = '1;
            shf_in       = '1;
            ss3_in       = ss3_ff | mres.set_ss3;
         end else if (mres.miss || next_ptr >= {1'b0, MAX_CNT}) begin
            // drop the ESC, held bytes after it get parsed again
            emit      = 1'b1;
            emit_code = {1'b0, ESC_CODE};
            shift     = CNT_W'(1);
            rd_ptr_in = '0;
            pri_in    = '1;
            shf_in    = '1;
         end else begin
            rd_ptr_in = next_ptr[CNT_W-1:0];
            pri_in    = mres.pri_cand;
            shf_in    = mres.shf_cand;
         end
      end
   end

   // buffer shift and append
   always_comb begin
      src     = 0;
      fill_in = fill_ff - shift;
      more_in = more_ff;
      for (int k = 0; k < MAX_SEQ_LEN; k++) begin
         src       = k + int'(shift);
         buf_in[k] = buf_ff[k];
         if (src < MAX_SEQ_LEN) begin
            buf_in[k] = buf_ff[POS_W'(src)];
         end
      end
      if (req_accept) begin
         buf_in[fill_ff[POS_W-1:0]] = req_data.key_byte[6:0];
         fill_in                    = fill_ff + 1'b1;
         more_in                    = req_data.more_waiting;
      end
   end

   // one result is kept back until it is known whether it ends the run
   always_comb begin
      push            = '0;
      pend_valid_in   = pend_valid_ff;
      pend_code_in    = pend_code_ff;
      pend_special_in = pend_special_ff;
      if (emit) begin
         push.valid            = pend_valid_ff;
         push.data.key_code    = pend_code_ff;
         push.data.special_key = pend_special_ff;
         pend_valid_in         = 1'b1;
         pend_code_in          = emit_code;
         pend_special_in       = emit_special;
      end else if (!busy && pend_valid_ff && out_free) begin
         push.valid            = 1'b1;
         push.data.key_code    = pend_code_ff;
         push.data.special_key = pend_special_ff;
         push.data.last_of_run = 1'b1;
         pend_valid_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rd_ptr_ff     <= '0;
         more_ff       <= 1'b0;
         pri_ff        <= '1;
         shf_ff        <= '1;
         ss3_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rd_ptr_ff     <= rd_ptr_in;
         more_ff       <= more_in;
         pri_ff        <= pri_in;
         shf_ff        <= shf_in;
         ss3_ff        <= ss3_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff          <= buf_in;
      pend_code_ff    <= pend_code_in;
      pend_special_ff <= pend_special_in;
   end

   assign status.busy       = busy;
   assign status.pend_valid = pend_valid_ff;
   assign status.rd_ptr     = rd_ptr_ff;
   assign status.fill       = fill_ff;

endmodule

// File: rtl/terminal_escape_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_unit
// Each request runs a match step for the new byte and for each replayed held
// byte on the single shared match step, while the output register is free; the
// last result is staged and then loaded into the result register. A new request
// waits until the last one is done. Reset is synchronous: counters, candidates,
// arrow mode and valids clear; held bytes and result payloads are not reset.
// ----------------------------------------------------------------------------
// Top level: request intake, sequencer with its shared match step, and the
// result register that parts the two channels.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tekd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tekd_pkg::rsp_type rsp_data
);
   import tekd_pkg::*;

   logic           req_accept;
   logic           out_free;
   push_type       push;
   seq_status_type status;

   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   // a new request waits until the previous one is fully parsed and its
   // last result has been handed to the output register
   assign req_stall  = status.busy || status.pend_valid;
   assign req_accept = req_valid && !req_stall;

   // output slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   tekd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .out_free   (out_free),
      .push       (push),
      .status     (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted request always leaves work behind for the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("accepted request left no work");

   // read pointer never passes the buffer fill, fill never passes the depth
   a_ptr_bounds: assert property (@(posedge clock) disable iff (reset)
      (status.rd_ptr <= status.fill) && (status.fill <= MAX_CNT))
      else $error("sequence buffer pointers out of range");

   // sequencer only pushes into a free result register
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed over an untaken result");

   // the end-of-run result drains the staged result
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.data.last_of_run) |=> !status.pend_valid)
      else $error("staged result left after end of run");
`endif

endmodule
